[hw/rtl/simt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simt_pkg
// Shared types and constants for the sorted interval merge table.
// ----------------------------------------------------------------------------
package simt_pkg;
   localparam int TimeWidth    = 63;
   localparam int IndexWidth   = 6;
   localparam int CountWidth   = 7;
   localparam int DefCapacity  = 64;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_ORDER = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [TimeWidth-1:0] first_tick;
      logic [TimeWidth-1:0] last_tick;
   } ival_type;

   // request and response payloads
   typedef struct packed {
      cmd_type               cmd;
      logic [TimeWidth-1:0]  first_tick;
      logic [TimeWidth-1:0]  last_tick;
      logic [IndexWidth-1:0] read_index;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [TimeWidth-1:0]  out_start;
      logic [TimeWidth-1:0]  out_end;
      logic [IndexWidth-1:0] position;
      logic [CountWidth-1:0] absorbed;
      logic [CountWidth-1:0] entry_count;
   } rsp_type;
endpackage

[hw/rtl/simt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simt_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface simt_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/simt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simt_cell
// One table slot. Takes new_in first, else the left neighbour on a shift
// (insert opens a gap), else the right-hand source on a pull (compaction).
// ----------------------------------------------------------------------------
module simt_cell (
   input  logic               clock,
   input  logic               take_left,
   input  logic               take_right,
   input  logic               take_new,
   input  simt_pkg::ival_type left_in,
   input  simt_pkg::ival_type right_in,
   input  simt_pkg::ival_type new_in,
   output simt_pkg::ival_type value_out
);
   import simt_pkg::*;
   ival_type value_ff;
   always_ff @(posedge clock) begin
      if (take_new) begin
         value_ff <= new_in;
      end else if (take_left) begin
         value_ff <= left_in;
      end else if (take_right) begin
         value_ff <= right_in;
      end
   end
   assign value_out = value_ff;
endmodule

[hw/rtl/sorted_interval_merge_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval merge table core; synchronous reset clears count and control only.
// Sequence: a read or malformed insert goes S_LO then S_DONE; an insert scans S_LO to the
//   first slot touched, S_HI over overlaps, then S_SHIFT, S_PULL or (full) S_DONE.
// One request in flight; the next is accepted the cycle after the response registers.
// ----------------------------------------------------------------------------
module sorted_interval_merge_table_core #(
   parameter int CAPACITY = simt_pkg::DefCapacity
) (
   input  logic clock,
   input  logic reset,
   simt_if.sink   req,
   simt_if.source rsp
);
   import simt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > IndexWidth) ? CW : IndexWidth;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LO    = 6'b000010,
      S_HI    = 6'b000100,
      S_SHIFT = 6'b001000,
      S_PULL  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [TimeWidth-1:0]  ms_ff, ms_in, me_ff, me_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   rsp_type               out_ff, out_in;

   ival_type cells [CAPACITY];
   logic [CAPACITY-1:0] take_left, take_right, take_new;
   ival_type new_val;
   ival_type cur_ff;

   assign new_val = '{first_tick: ms_ff, last_tick: me_ff};

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         ival_type l_in, r_in;
         if (g == 0) begin : g_l0
            assign l_in = cells[0];
         end else begin : g_ln
            assign l_in = cells[g-1];
         end
         if (g == CAPACITY - 1) begin : g_rl
            assign r_in = cells[g];
         end else begin : g_rn
            assign r_in = cells[g+1];
         end
         simt_cell u_cell (
            .clock     (clock),
            .take_left (take_left[g]),
            .take_right(take_right[g]),
            .take_new  (take_new[g]),
            .left_in   (l_in),
            .right_in  (r_in),
            .new_in    (new_val),
            .value_out (cells[g])
         );
      end
   endgenerate

   // cell enables: shift opens a gap at lo, pull closes one slot above lo
   always_comb begin
      take_left  = '0;
      take_right = '0;
      take_new   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (state_ff == S_SHIFT) begin
            take_left[i] = (CW'(i) > lo_ff) && (CW'(i) <= count_ff);
            take_new[i]  = (CW'(i) == lo_ff);
         end
         if (state_ff == S_PULL) begin
            // the last pull cycle only rewrites the merged slot
            take_right[i] = (hi_ff - lo_ff > CW'(1)) && (CW'(i) > lo_ff)
                            && (CW'(i) + 1'b1 < count_ff);
            take_new[i]   = (CW'(i) == lo_ff);
         end
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      ms_in        = ms_ff;
      me_in        = me_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      out_in       = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               ptr_in   = (req.data.cmd == CMD_READ) ? CW'(req.data.read_index) : '0;
               lo_in    = '0;
               ms_in    = req.data.first_tick;
               me_in    = req.data.last_tick;
               state_in = S_LO;
            end
         end
         S_LO: begin
            if (req_ff.cmd == CMD_READ) begin
               rsp_in = '0;
               rsp_in.entry_count = CountWidth'(count_ff);
               if (XW'(req_ff.read_index) >= XW'(count_ff)) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  rsp_in.status    = ST_OK;
                  rsp_in.out_start = cur_ff.first_tick;
                  rsp_in.out_end   = cur_ff.last_tick;
                  rsp_in.position  = req_ff.read_index;
               end
               state_in = S_DONE;
            end else if (ms_ff > me_ff) begin
               rsp_in = '0;
               rsp_in.status = ST_ORDER;
               rsp_in.entry_count = CountWidth'(count_ff);
               state_in = S_DONE;
            end else if (ptr_ff < count_ff && cur_ff.last_tick < ms_ff) begin
               ptr_in = ptr_ff + 1'b1;
            end else begin
               lo_in    = ptr_ff;
               hi_in    = ptr_ff;
               state_in = S_HI;
            end
         end
         S_HI: begin
            if (ptr_ff < count_ff && cur_ff.first_tick <= me_ff) begin
               if (ptr_ff == lo_ff && cur_ff.first_tick < ms_ff) begin
                  ms_in = cur_ff.first_tick;
               end
               if (cur_ff.last_tick > me_ff) begin
                  me_in = cur_ff.last_tick;
               end
               ptr_in = ptr_ff + 1'b1;
               hi_in  = ptr_ff + 1'b1;
            end else if (hi_ff == lo_ff) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  rsp_in = '0;
                  rsp_in.status = ST_FULL;
                  rsp_in.entry_count = CountWidth'(count_ff);
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else begin
               state_in = S_PULL;
            end
         end
         S_SHIFT: begin
            count_in = count_ff + 1'b1;
            rsp_in.status      = ST_OK;
            rsp_in.out_start   = ms_ff;
            rsp_in.out_end     = me_ff;
            rsp_in.position    = IndexWidth'(lo_ff);
            rsp_in.absorbed    = '0;
            rsp_in.entry_count = CountWidth'(count_ff + 1'b1);
            state_in = S_DONE;
         end
         S_PULL: begin
            // each pull but the last removes one absorbed slot above lo
            if (hi_ff - lo_ff > CW'(1)) begin
               count_in = count_ff - 1'b1;
               hi_in    = hi_ff - 1'b1;
            end else begin
               rsp_in.status      = ST_OK;
               rsp_in.out_start   = ms_ff;
               rsp_in.out_end     = me_ff;
               rsp_in.position    = IndexWidth'(lo_ff);
               rsp_in.absorbed    = CountWidth'(ptr_ff - lo_ff);
               rsp_in.entry_count = CountWidth'(count_ff);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_in       = rsp_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid && req.ready) begin
         req_ff <= req.data;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      ptr_ff <= ptr_in;
      ms_ff  <= ms_in;
      me_ff  <= me_in;
      rsp_ff <= rsp_in;
      out_ff <= out_in;
      cur_ff <= cells[ptr_in[AW-1:0]];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count above capacity");
   a_busy_noready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp.valid) else $error("missing response");
endmodule

[bench/tb_sorted_interval_merge_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_interval_merge_table_core
// Self-checking bench for the interval merge table. A short table of
// directed requests comes first, then a long random mix of inserts, reads
// and malformed intervals, mostly under random idling on both channels. Every
// response is checked whole against its row's want or the bench table model.
// ----------------------------------------------------------------------------
module tb_sorted_interval_merge_table_core;
   import simt_pkg::*;

   localparam int Capacity = DefCapacity;
   localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};
   localparam int StallLimit = 4000;
   localparam int HoldCycles = 500;
   localparam int RandItems  = 610;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   simt_if #(.payload_type(req_type)) req_ch ();
   simt_if #(.payload_type(rsp_type)) rsp_ch ();

   sorted_interval_merge_table_core #(.CAPACITY(Capacity)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // bench copy of the table
   logic [TimeWidth-1:0] tbl_start [Capacity];
   logic [TimeWidth-1:0] tbl_end   [Capacity];
   int                   tbl_count;

   rsp_type   expected_q[$];
   int        errors;
   int        send_idle_pct;
   int        recv_idle_pct;
   logic      pressure_req;
   logic      pending_typed;
   rsp_type   pending_want;

   localparam int NumDir = 16;
   dir_row_type dir_rows [NumDir] = '{
      '{'{CMD_READ, 63'd0, 63'd0, 6'd0}, 1'b1, '{ST_RANGE, 63'd0, 63'd0, 6'd0, 7'd0, 7'd0}},
      '{'{CMD_READ, 63'd0, 63'd0, 6'd63}, 1'b1, '{ST_RANGE, 63'd0, 63'd0, 6'd0, 7'd0, 7'd0}},
      '{'{CMD_INSERT, 63'd5, 63'd4, 6'd0}, 1'b1, '{ST_ORDER, 63'd0, 63'd0, 6'd0, 7'd0, 7'd0}},
      '{'{CMD_INSERT, TimeMax, TimeMax, 6'd63}, 1'b1,
        '{ST_OK, TimeMax, TimeMax, 6'd0, 7'd0, 7'd1}},
      '{'{CMD_INSERT, 63'd0, 63'd0, 6'd0}, 1'b1, '{ST_OK, 63'd0, 63'd0, 6'd0, 7'd0, 7'd2}},
      '{'{CMD_INSERT, TimeMax, 63'd0, 6'd0}, 1'b1,
        '{ST_ORDER, 63'd0, 63'd0, 6'd0, 7'd0, 7'd2}},
      '{'{CMD_READ, 63'd7, 63'd3, 6'd1}, 1'b1, '{ST_OK, TimeMax, TimeMax, 6'd1, 7'd0, 7'd2}},
      '{'{CMD_READ, 63'd0, 63'd0, 6'd2}, 1'b1, '{ST_RANGE, 63'd0, 63'd0, 6'd0, 7'd0, 7'd2}},
      '{'{CMD_INSERT, 63'd1, 63'd1, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd1, 63'd10, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd10, 63'd20, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd100, 63'd200, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd300, 63'd400, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd150, 63'd350, 6'd0}, 1'b0, '0},
      '{'{CMD_INSERT, 63'd0, TimeMax, 6'd0}, 1'b1, '{ST_OK, 63'd0, TimeMax, 6'd0, 7'd4, 7'd1}},
      '{'{CMD_READ, TimeMax, TimeMax, 6'd0}, 1'b0, '0}
   };

   // applies one request to the bench table and returns the response it gives
   function automatic rsp_type apply_request(req_type q);
      rsp_type r;
      int n;
      int lo;
      int hi;
      int gone;
      logic [TimeWidth-1:0] ms;
      logic [TimeWidth-1:0] me;
      r = '0;
      n = tbl_count;
      r.entry_count = CountWidth'(n);
      if (q.cmd == CMD_READ) begin
         if (q.read_index >= n) begin
            r.status = ST_RANGE;
         end else begin
            r.status = ST_OK;
            r.out_start = tbl_start[q.read_index];
            r.out_end = tbl_end[q.read_index];
            r.position = q.read_index;
         end
         return r;
      end
      if (q.first_tick > q.last_tick) begin
         r.status = ST_ORDER;
         return r;
      end
      lo = 0;
      while (lo < n && tbl_end[lo] < q.first_tick) lo++;
      hi = lo;
      while (hi < n && tbl_start[hi] <= q.last_tick) hi++;
      gone = hi - lo;
      if (gone == 0) begin
         if (n >= Capacity) begin
            r.status = ST_FULL;
            return r;
         end
         for (int k = n; k > lo; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k] = tbl_end[k-1];
         end
         ms = q.first_tick;
         me = q.last_tick;
         n++;
      end else begin
         ms = tbl_start[lo] < q.first_tick ? tbl_start[lo] : q.first_tick;
         me = tbl_end[hi-1] > q.last_tick ? tbl_end[hi-1] : q.last_tick;
         for (int k = hi; k < n; k++) begin
            tbl_start[k-gone+1] = tbl_start[k];
            tbl_end[k-gone+1] = tbl_end[k];
         end
         n = n - gone + 1;
      end
      tbl_start[lo] = ms;
      tbl_end[lo] = me;
      tbl_count = n;
      r.status = ST_OK;
      r.out_start = ms;
      r.out_end = me;
      r.position = IndexWidth'(lo);
      r.absorbed = CountWidth'(gone);
      r.entry_count = CountWidth'(n);
      return r;
   endfunction

   function automatic logic [TimeWidth-1:0] rand_time();
      return TimeWidth'({$urandom, $urandom});
   endfunction

   function automatic req_type rand_request();
      req_type q;
      int pick;
      int len;
      logic [TimeWidth-1:0] a;
      logic [TimeWidth-1:0] b;
      q = '0;
      q.cmd = CMD_INSERT;
      q.read_index = IndexWidth'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) begin
         q.cmd = CMD_READ;
         q.first_tick = rand_time();
         q.last_tick = rand_time();
         if ($urandom_range(3) != 0)
            q.read_index = IndexWidth'($urandom_range(tbl_count < 63 ? tbl_count + 1 : 63, 0));
      end else if (pick < 26) begin
         // malformed interval
         a = rand_time();
         b = rand_time();
         if (a == b) b = a - TimeWidth'(1);
         q.first_tick = a > b ? a : b;
         q.last_tick = a > b ? b : a;
      end else if (pick < 34) begin
         a = rand_time();
         b = rand_time();
         q.first_tick = a < b ? a : b;
         q.last_tick = a < b ? b : a;
      end else if (pick < 38) begin
         q.first_tick = TimeMax - TimeWidth'($urandom_range(40));
         q.last_tick = TimeMax - TimeWidth'($urandom_range(q.first_tick == TimeMax ? 0 :
                                                32'(TimeMax - q.first_tick)));
      end else if (pick < 44 && tbl_count > 0) begin
         // start on an existing end tick, shared endpoint
         q.first_tick = tbl_end[$urandom_range(tbl_count - 1)];
         q.last_tick = q.first_tick + TimeWidth'($urandom_range(3));
         if (q.last_tick < q.first_tick) q.last_tick = TimeMax;
      end else begin
         len = ($urandom_range(99) < 88) ? $urandom_range(6) : $urandom_range(800);
         q.first_tick = TimeWidth'($urandom_range(2000));
         q.last_tick = q.first_tick + TimeWidth'(len);
      end
      return q;
   endfunction

   task automatic send_request(req_type q, logic typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pending_typed <= typed;
      pending_want <= want;
      req_ch.valid <= 1'b1;
      req_ch.data <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      errors++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request monitor: updates the model on every accepted request
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && req_ch.valid && req_ch.ready) begin
         r = apply_request(req_ch.data);
         expected_q.insert(expected_q.size(), pending_typed ? pending_want : r);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type w;
      rsp_type g;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         g = rsp_ch.data;
         if (expected_q.size() == 0) begin
            report_mismatch("response with nothing outstanding", g, '0);
         end else begin
            w = expected_q.pop_front();
            if (g !== w) report_mismatch("response", g, w);
         end
      end
   end

   // receiver, with one long hold-off on request
   initial begin
      int held;
      held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_req && held < HoldCycles) begin
            held++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      tbl_count = 0;
      pressure_req = 1'b0;
      pending_typed = 1'b0;
      pending_want = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 58;
      foreach (dir_rows[i]) send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 58;
            recv_idle_pct = 15;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            pressure_req = 1'b1;
         end
         for (int i = 0; i < RandItems; i++) send_request(rand_request(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (expected_q.size() != 0) @(posedge clock);
      repeat (2 * Capacity + 10) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
